[src/utf8_unique_codepoint_extractor_defines.svh]
// assertion macros used by the extractor's filter module
`ifndef UTF8_UNIQUE_CODEPOINT_EXTRACTOR_DEFINES_SVH
`define UTF8_UNIQUE_CODEPOINT_EXTRACTOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define UCX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define UCX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/ucx_pkg.sv]
// shared constants, types and helpers for the unique code point extractor
package ucx_pkg;

  // code point space covered by the seen bitmap
  localparam int CODE_SPACE = 1114112;
  localparam int CP_W       = 21;
  localparam int BYTE_W     = 8;

  // bitmap memory geometry: one row holds 32 flags
  localparam int ROW_W  = 32;
  localparam int BIT_AW = $clog2(ROW_W);
  localparam int ROWS   = (CODE_SPACE + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // code point limits
  localparam logic [CP_W-1:0] CP_LIMIT = 21'h110000;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;

  // decoded candidate handed to the bitmap filter
  typedef struct packed {
    logic            vld;
    logic [CP_W-1:0] cp;
  } cand_t;

  // nonzero scalar value that fits the bitmap
  function automatic logic cp_ok(input logic [CP_W-1:0] cp);
    logic in_surr;
    in_surr = (cp >= SURR_LO) && (cp <= SURR_HI);
    return (cp != '0) && (cp < CP_LIMIT) && (cp < CP_W'(CODE_SPACE)) && !in_surr;
  endfunction

  // bitmap row of a code point
  function automatic logic [ROW_AW-1:0] cp_row(input logic [CP_W-1:0] cp);
    return ROW_AW'(cp >> BIT_AW);
  endfunction

endpackage

[src/ucx_if.sv]
// valid/ready channel interfaces for byte requests and result requests
interface ucx_in_if;
  logic                      valid;
  logic                      ready;
  logic [ucx_pkg::BYTE_W-1:0] data_byte;
  logic                      end_of_file;

  modport source (output valid, data_byte, end_of_file, input ready);
  modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

interface ucx_out_if;
  logic                     valid;
  logic                     ready;
  logic [ucx_pkg::CP_W-1:0] code_point;
  logic [ucx_pkg::CP_W-1:0] ordinal;

  modport source (output valid, code_point, ordinal, input ready);
  modport sink   (input valid, code_point, ordinal, output ready);
endinterface

[src/utf8_unique_codepoint_extractor.sv]
// top level of the utf-8 unique code point extractor
//
// in_chan carries one byte request per handshake: data_byte and end_of_file,
// the latter marking the last byte of a file (an unfinished sequence is then
// dropped). out_chan carries one request for each code point seen for the
// first time since reset: code_point and its ordinal in the unique set.
// Both channels move a request when valid and ready are high at a clock edge.
// Throughput is one byte per cycle when out_chan does not stall. The decode
// and the bitmap read are issued when a byte is taken; the lookup stage then
// checks and writes back the 32-flag row and loads the result register.
// Back-to-back hits on the same row are forwarded from the last write.
// After reset the bitmap is cleared one row per cycle, all ROWS = 34816 rows,
// during which in_chan.ready stays low; the count and decoder start at zero.
// A stalled receiver holds the result register; one more byte can sit in
// the lookup stage, after which in_chan.ready drops until out_chan drains.
module utf8_unique_codepoint_extractor (
  input  logic      clk,
  input  logic      rst_n,
  ucx_in_if.sink    in_chan,
  ucx_out_if.source out_chan
);
  import ucx_pkg::*;

  cand_t cand;
  logic  ready;
  logic  acc;

  assign in_chan.ready = ready;
  assign acc           = in_chan.valid && ready;

  // byte decoder
  ucx_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .data_byte   (in_chan.data_byte),
    .end_of_file (in_chan.end_of_file),
    .cand        (cand)
  );

  // seen filter and result register
  ucx_filter u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .cand     (cand),
    .ready    (ready),
    .out_chan (out_chan)
  );

endmodule

[src/ucx_ram.sv]
// generic single-write, single-read ram with registered read data
module ucx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/ucx_decode.sv]
// utf-8 sequence decoder: assembles code points byte by byte
module ucx_decode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic [ucx_pkg::BYTE_W-1:0] data_byte,
  input  logic                       end_of_file,
  output ucx_pkg::cand_t             cand
);
  import ucx_pkg::*;

  logic [CP_W-1:0] partial_r, partial_nxt;
  logic [1:0]      remain_r, remain_nxt;
  logic [CP_W-1:0] shifted;
  logic            is_cont;

  assign is_cont = (data_byte[7:6] == 2'b10);
  assign shifted = {partial_r[CP_W-7:0], data_byte[5:0]};

  // next sequence state and completed value
  always_comb begin
    partial_nxt = partial_r;
    remain_nxt  = remain_r;
    cand.vld    = 1'b0;
    cand.cp     = shifted;
    if ((remain_r != 2'd0) && is_cont) begin
      partial_nxt = shifted;
      remain_nxt  = remain_r - 2'd1;
      if (remain_r == 2'd1) begin
        cand.vld    = cp_ok(shifted);
        partial_nxt = '0;
      end
    end else begin
      // lead byte, also after a broken sequence
      partial_nxt = '0;
      remain_nxt  = 2'd0;
      if (data_byte[7] == 1'b0) begin
        cand.cp  = CP_W'(data_byte);
        cand.vld = cp_ok(CP_W'(data_byte));
      end else if (data_byte[7:5] == 3'b110) begin
        partial_nxt = CP_W'(data_byte[4:0]);
        remain_nxt  = 2'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
        partial_nxt = CP_W'(data_byte[3:0]);
        remain_nxt  = 2'd2;
      end else if (data_byte[7:3] == 5'b11110) begin
        partial_nxt = CP_W'(data_byte[2:0]);
        remain_nxt  = 2'd3;
      end
    end
    // end of file drops any unfinished sequence
    if (end_of_file) begin
      partial_nxt = '0;
      remain_nxt  = 2'd0;
    end
  end

  // sequence state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      remain_r  <= 2'd0;
    end else if (acc) begin
      partial_r <= partial_nxt;
      remain_r  <= remain_nxt;
    end
  end

endmodule

[src/ucx_filter.sv]
// seen-bitmap read-modify-write, ordinal counter and result register
`include "utf8_unique_codepoint_extractor_defines.svh"

module ucx_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  ucx_pkg::cand_t     cand,
  output logic               ready,
  ucx_out_if.source          out_chan
);
  import ucx_pkg::*;

  logic              clearing_r, clearing_nxt;
  logic [ROW_AW-1:0] clr_row_r, clr_row_nxt;
  logic              s1_vld_r, s1_vld_nxt;
  logic [CP_W-1:0]   s1_cp_r, s1_cp_nxt;
  logic              fwd_vld_r, fwd_vld_nxt;
  logic [ROW_AW-1:0] fwd_row_r, fwd_row_nxt;
  logic [ROW_W-1:0]  fwd_data_r, fwd_data_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [CP_W-1:0]   out_cp_r, out_cp_nxt;
  logic [CP_W-1:0]   out_ord_r, out_ord_nxt;
  logic [CP_W-1:0]   total_r, total_nxt;

  logic              s1_go, s1_fire, seen, emit;
  logic [ROW_AW-1:0] s1_row;
  logic [ROW_W-1:0]  ram_rdata, row_data, bit_mask;
  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;

  // bitmap storage
  ucx_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_seen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (acc && cand.vld),
    .raddr (cp_row(cand.cp)),
    .rdata (ram_rdata)
  );

  // stage handshake
  assign s1_go   = !out_vld_r || out_chan.ready;
  assign ready   = !clearing_r && (!s1_vld_r || s1_go);
  assign s1_fire = s1_vld_r && s1_go;

  // row lookup with forwarding of the write issued alongside our read
  assign s1_row   = cp_row(s1_cp_r);
  assign row_data = (fwd_vld_r && (fwd_row_r == s1_row)) ? fwd_data_r : ram_rdata;
  assign bit_mask = ROW_W'(1) << s1_cp_r[BIT_AW-1:0];
  assign seen     = |(row_data & bit_mask);
  assign emit     = s1_fire && !seen;

  // write port: clearing pass after reset, else set the flag
  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_row_r;
      ram_wdata = '0;
    end else begin
      ram_we    = emit;
      ram_waddr = s1_row;
      ram_wdata = row_data | bit_mask;
    end
  end

  // next-state logic
  always_comb begin
    clearing_nxt = clearing_r;
    clr_row_nxt  = clr_row_r;
    if (clearing_r) begin
      clr_row_nxt = clr_row_r + ROW_AW'(1);
      if (clr_row_r == ROW_AW'(ROWS - 1)) begin
        clearing_nxt = 1'b0;
      end
    end

    s1_vld_nxt = s1_vld_r;
    s1_cp_nxt  = s1_cp_r;
    if (acc) begin
      s1_vld_nxt = cand.vld;
      s1_cp_nxt  = cand.cp;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end

    // forwarding tracks the most recent flag write
    fwd_vld_nxt  = fwd_vld_r;
    fwd_row_nxt  = fwd_row_r;
    fwd_data_nxt = fwd_data_r;
    if (clearing_r) begin
      fwd_vld_nxt = 1'b0;
    end else if (emit) begin
      fwd_vld_nxt  = 1'b1;
      fwd_row_nxt  = s1_row;
      fwd_data_nxt = ram_wdata;
    end

    out_vld_nxt = out_vld_r;
    out_cp_nxt  = out_cp_r;
    out_ord_nxt = out_ord_r;
    total_nxt   = total_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
      out_cp_nxt  = s1_cp_r;
      out_ord_nxt = total_r;
      total_nxt   = total_r + CP_W'(1);
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_row_r  <= '0;
      s1_vld_r   <= 1'b0;
      fwd_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
      total_r    <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_row_r  <= clr_row_nxt;
      s1_vld_r   <= s1_vld_nxt;
      fwd_vld_r  <= fwd_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      total_r    <= total_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_cp_r    <= s1_cp_nxt;
    fwd_row_r  <= fwd_row_nxt;
    fwd_data_r <= fwd_data_nxt;
    out_cp_r   <= out_cp_nxt;
    out_ord_r  <= out_ord_nxt;
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.code_point = out_cp_r;
  assign out_chan.ordinal    = out_ord_r;

  // checks
  `UCX_ASSERT_IMP(a_no_accept_in_clear, clearing_r, !acc)
  `UCX_ASSERT_IMP(a_out_is_scalar, out_vld_r, cp_ok(out_cp_r))
  `UCX_ASSERT_NXT(a_ordinal_steps, emit, total_r == $past(total_r) + CP_W'(1))
  `UCX_ASSERT_NXT(a_stall_holds_s1, s1_vld_r && !s1_go, s1_vld_r && $stable(s1_cp_r))

endmodule

[sim/utf8_unique_codepoint_extractor_tb.sv]
// self-checking testbench for the utf-8 unique code point extractor
`timescale 1ns / 1ps

module utf8_unique_codepoint_extractor_tb;
  import ucx_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int DIR_ROWS     = 26;
  localparam int STALL_LIMIT  = 200000;  // covers the bitmap clearing pass after reset
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;

  // how a directed row gets its expected result
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_RESULT,
    ROW_RESULT
  } row_kind_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic [CP_W-1:0] ordinal;
  } cp_result_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              eof;
    row_kind_t         kind;
    logic [CP_W-1:0]   cp;
    logic [CP_W-1:0]   ord;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic rcv_ready = 1'b0;

  ucx_in_if  in_chan ();
  ucx_out_if out_chan ();

  assign out_chan.ready = rcv_ready;

  utf8_unique_codepoint_extractor uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #2 clk = ~clk;

  // decoder state mirrored by the testbench
  logic [CP_W-1:0] dec_partial = '0;
  logic [1:0]      dec_remaining = '0;
  logic [CP_W-1:0] next_ordinal = '0;
  bit              seen_cps [logic [CP_W-1:0]];

  cp_result_t  pending_results [$];
  int unsigned fail_count = 0;
  int unsigned byte_count = 0;
  int unsigned snd_idle_pct = 23;
  int unsigned rcv_idle_pct = 76;
  bit          hold_armed = 1'b0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned quiet_cycles = 0;

  // first sighting of a valid scalar value gets the next ordinal
  function automatic logic admit_code_point(input logic [CP_W-1:0] cp, output cp_result_t r);
    r = '0;
    if (cp == '0 || cp >= CP_LIMIT || cp >= CP_W'(CODE_SPACE)) return 1'b0;
    if (cp >= SURR_LO && cp <= SURR_HI) return 1'b0;
    if (seen_cps.exists(cp)) return 1'b0;
    seen_cps[cp] = 1'b1;
    r.code_point = cp;
    r.ordinal    = next_ordinal;
    next_ordinal = next_ordinal + 1'b1;
    return 1'b1;
  endfunction

  // one byte through the decoder, returns 1 when a new code point appears
  function automatic logic decode_byte(input logic [BYTE_W-1:0] b, input logic eof,
                                       output cp_result_t r);
    logic hit;
    hit = 1'b0;
    r = '0;
    if (dec_remaining != 2'd0 && b[7:6] == 2'b10) begin
      dec_partial   = {dec_partial[CP_W-7:0], b[5:0]};
      dec_remaining = dec_remaining - 2'd1;
      if (dec_remaining == 2'd0) begin
        hit = admit_code_point(dec_partial, r);
        dec_partial = '0;
      end
    end else begin
      // bad continuation drops the partial value, byte treated as a lead
      dec_partial   = '0;
      dec_remaining = 2'd0;
      if (!b[7]) begin
        hit = admit_code_point(CP_W'(b), r);
      end else if (b[7:5] == 3'b110) begin
        dec_partial   = CP_W'(b[4:0]);
        dec_remaining = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        dec_partial   = CP_W'(b[3:0]);
        dec_remaining = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        dec_partial   = CP_W'(b[2:0]);
        dec_remaining = 2'd3;
      end
    end
    if (eof) begin
      dec_partial   = '0;
      dec_remaining = 2'd0;
    end
    return hit;
  endfunction

  // utf-8 bytes of cp in n bytes, longer than needed gives an overlong form
  function automatic void encode_utf8(input logic [CP_W-1:0] cp, input int n,
                                      output logic [BYTE_W-1:0] seq [4]);
    seq = '{default: 8'h00};
    case (n)
      1: begin
        seq[0] = cp[7:0];
      end
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
  endfunction

  // offer one byte request, wait for it to be taken, then log what it should yield
  task automatic send_request(input logic [BYTE_W-1:0] b, input logic eof,
                              input row_kind_t kind, input cp_result_t typed);
    cp_result_t pred;
    logic       got;
    logic       hit;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.data_byte   <= b;
    in_chan.end_of_file <= eof;
    got = 1'b0;
    while (!got) begin
      @(negedge clk);
      got = in_chan.ready;
      @(posedge clk);
    end
    byte_count = byte_count + 1;
    hit = decode_byte(b, eof, pred);
    case (kind)
      ROW_PREDICT:   if (hit) pending_results.push_back(pred);
      ROW_RESULT:    pending_results.push_back(typed);
      ROW_NO_RESULT: ;
      default:       ;
    endcase
  endtask

  // receiver ready, with one long hold-off once the no-idle phase starts
  always @(posedge clk) begin
    if (!rst_n) begin
      rcv_ready <= 1'b0;
    end else if (hold_left != 0) begin
      rcv_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      rcv_ready <= 1'b0;
    end else begin
      rcv_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // compare each result request with the oldest expectation
  always @(negedge clk) begin
    cp_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: code_point %h ordinal %0d",
               out_chan.code_point, out_chan.ordinal);
        fail_count = fail_count + 1;
      end else begin
        want = pending_results.pop_front();
        if (out_chan.code_point !== want.code_point) begin
          $error("code_point: expected %h, got %h", want.code_point, out_chan.code_point);
          fail_count = fail_count + 1;
        end
        if (out_chan.ordinal !== want.ordinal) begin
          $error("ordinal: expected %0d, got %0d", want.ordinal, out_chan.ordinal);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(negedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // reset, directed table, random traffic, drain
  initial begin
    stim_row_t           dir_rows [DIR_ROWS];
    logic [BYTE_W-1:0]   seq [4];
    logic [CP_W-1:0]     cp;
    int                  nbytes;
    int                  cut;
    int unsigned         roll;
    cp_result_t          typed;

    in_chan.valid       <= 1'b0;
    in_chan.data_byte   <= '0;
    in_chan.end_of_file <= 1'b0;

    dir_rows = '{
      '{8'h41, 1'b0, ROW_RESULT,    21'h000041, 21'd0},  // ascii
      '{8'h41, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},  // repeat is filtered
      '{8'h00, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},  // zero rejected
      '{8'h7F, 1'b0, ROW_RESULT,    21'h00007F, 21'd1},
      '{8'h80, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},  // stray continuation
      '{8'hFF, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},  // invalid lead
      '{8'hC2, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},
      '{8'hA9, 1'b0, ROW_RESULT,    21'h0000A9, 21'd2},
      '{8'hC0, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},  // overlong zero
      '{8'h80, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},
      '{8'hE2, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},
      '{8'h82, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},
      '{8'hAC, 1'b0, ROW_RESULT,    21'h0020AC, 21'd3},
      '{8'hED, 1'b0, ROW_PREDICT,   21'h0,      21'd0},  // surrogate
      '{8'hA0, 1'b0, ROW_PREDICT,   21'h0,      21'd0},
      '{8'h80, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},
      '{8'hF4, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},  // top of the code space
      '{8'h8F, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},
      '{8'hBF, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},
      '{8'hBF, 1'b0, ROW_RESULT,    21'h10FFFF, 21'd4},
      '{8'hE2, 1'b0, ROW_PREDICT,   21'h0,      21'd0},  // bad continuation
      '{8'h42, 1'b0, ROW_RESULT,    21'h000042, 21'd5},
      '{8'hE2, 1'b1, ROW_NO_RESULT, 21'h0,      21'd0},  // end of file mid sequence
      '{8'hAC, 1'b0, ROW_NO_RESULT, 21'h0,      21'd0},
      '{8'hC3, 1'b0, ROW_PREDICT,   21'h0,      21'd0},
      '{8'hA9, 1'b1, ROW_RESULT,    21'h0000E9, 21'd6}   // completed on the last byte
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      typed.code_point = dir_rows[i].cp;
      typed.ordinal    = dir_rows[i].ord;
      send_request(dir_rows[i].data, dir_rows[i].eof, dir_rows[i].kind, typed);
    end

    // random traffic: mostly well-formed sequences, some noise and truncation
    while (byte_count < DIR_ROWS + RANDOM_ITEMS) begin
      if (byte_count < DIR_ROWS + RANDOM_ITEMS / 3) begin
        snd_idle_pct = 23;
        rcv_idle_pct = 76;
      end else if (byte_count < DIR_ROWS + 2 * RANDOM_ITEMS / 3) begin
        snd_idle_pct = 76;
        rcv_idle_pct = 23;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_armed   = 1'b1;
      end

      roll = $urandom_range(99);
      if (roll < 10) begin
        send_request(BYTE_W'($urandom_range(255)), $urandom_range(31) == 0, ROW_PREDICT, '0);
      end else begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5: cp = CP_W'($urandom_range(1, 127));
          6, 7, 8, 9, 10:   cp = CP_W'($urandom_range(21'h80, 21'h7FF));
          11, 12, 13, 14:   cp = CP_W'($urandom_range(21'h800, 21'hFFFF));
          15, 16, 17, 18:   cp = CP_W'($urandom_range(21'h10000, 21'h10FFFF));
          default:          cp = CP_W'($urandom_range(21'h1FFFFF));
        endcase
        nbytes = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
        if (nbytes < 4 && $urandom_range(9) == 0) nbytes = nbytes + 1;
        if (roll < 18 && nbytes == 1) nbytes = 2;
        encode_utf8(cp, nbytes, seq);

        if (roll < 18) begin
          // truncated sequence, cut by end of file or by a new lead
          cut = $urandom_range(1, nbytes - 1);
          if ($urandom_range(1) == 0) begin
            for (int k = 0; k < cut; k++) send_request(seq[k], k == cut - 1, ROW_PREDICT, '0);
          end else begin
            for (int k = 0; k < cut; k++) send_request(seq[k], 1'b0, ROW_PREDICT, '0);
            send_request(BYTE_W'($urandom_range(127)), 1'b0, ROW_PREDICT, '0);
          end
        end else begin
          for (int k = 0; k < nbytes; k++) begin
            send_request(seq[k], (k == nbytes - 1) && ($urandom_range(19) == 0),
                         ROW_PREDICT, '0);
          end
        end
      end
    end
    in_chan.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
